// ===== hdl/apc_pkg.sv =====
package apc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_UP     = 3'd1,
    MODE_DOWN   = 3'd2,
    MODE_P1     = 3'd3,
    MODE_P2     = 3'd4,
    MODE_P3     = 3'd5,
    MODE_P4     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_UP   = 2'd1,
    DRV_DOWN = 2'd2
  } drive_t;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 12;
  localparam int ERR_BITS       = 15;
  localparam int FULL_BITS      = 10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESET_ONE   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESET_TWO   = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESET_THREE = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESET_FOUR  = 8'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE        = 8'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SCALE   = 8'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE       = 8'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEAVE        = 8'd7;

  localparam logic signed [ERR_BITS-1:0] ERR_MAX = 15'sd16383;
  localparam logic signed [ERR_BITS-1:0] ERR_MIN = -15'sd16384;

  typedef struct packed {
    logic [3:0][11:0]        preset_pos;
    logic [3:0]              scale_factor;
    logic [FULL_BITS-1:0]    sample_full_scale;
    logic [7:0]              settle_threshold;
    logic [7:0]              leave_threshold;
  } cfg_t;

  typedef struct packed {
    mode_t  mode;
    logic   seeking;
    drive_t drive;
  } state_t;

  typedef struct packed {
    logic       button_up;
    logic       button_down;
    logic [3:0] preset;
  } buttons_t;

endpackage

// ===== hdl/apc_item_if.sv =====
interface apc_item_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic                   button_up;
  logic                   button_down;
  logic                   preset_one;
  logic                   preset_two;
  logic                   preset_three;
  logic                   preset_four;
  logic [SAMPLE_BITS-1:0] shoulder_sample;

  modport source (output valid, button_up, button_down, preset_one, preset_two,
                  preset_three, preset_four, shoulder_sample, input ready);
  modport sink (input valid, button_up, button_down, preset_one, preset_two,
                preset_three, preset_four, shoulder_sample, output ready);
endinterface

// ===== hdl/apc_result_if.sv =====
interface apc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_drive;
  logic [2:0]         control_mode;
  logic signed [14:0] position_error;

  modport source (output valid, motor_drive, control_mode, position_error, input ready);
  modport sink (input valid, motor_drive, control_mode, position_error, output ready);
endinterface

// ===== hdl/apc_cfg_if.sv =====
interface apc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/apc_cfg_regs.sv =====
module apc_cfg_regs
  import apc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  apc_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.preset_pos[0]     <= 12'd4;
      regs.preset_pos[1]     <= 12'd180;
      regs.preset_pos[2]     <= 12'd676;
      regs.preset_pos[3]     <= 12'd1140;
      regs.scale_factor      <= 4'd4;
      regs.sample_full_scale <= 10'd1023;
      regs.settle_threshold  <= 8'd20;
      regs.leave_threshold   <= 8'd45;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PRESET_ONE:   regs.preset_pos[0]     <= cfg.data;
        REG_PRESET_TWO:   regs.preset_pos[1]     <= cfg.data;
        REG_PRESET_THREE: regs.preset_pos[2]     <= cfg.data;
        REG_PRESET_FOUR:  regs.preset_pos[3]     <= cfg.data;
        REG_SCALE:        regs.scale_factor      <= cfg.data[3:0];
        REG_FULL_SCALE:   regs.sample_full_scale <= cfg.data[FULL_BITS-1:0];
        REG_SETTLE:       regs.settle_threshold  <= cfg.data[7:0];
        REG_LEAVE:        regs.leave_threshold   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/apc_step.sv =====
module apc_step
  import apc_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  cfg_t                          regs,
  input  state_t                        state,
  input  buttons_t                      btn,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output state_t                        state_next,
  output logic signed [ERR_BITS-1:0]    error
);

  localparam int DW = (SAMPLE_BITS > FULL_BITS ? SAMPLE_BITS : FULL_BITS) + 1;
  localparam int PW = DW + 5;
  localparam int EW = PW + 1;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] pos;
  logic [1:0]           which;
  logic signed [EW-1:0] target;
  logic signed [EW-1:0] err_full;
  logic [EW-1:0]        mag;
  logic                 any_preset;
  logic                 other;
  logic                 seeking_preset;
  logic                 seek_new;
  logic signed [EW-1:0] err_cmp;

  always_comb begin
    diff = DW'(signed'({1'b0, regs.sample_full_scale})) - DW'(signed'({1'b0, sample}));
    pos  = PW'(diff) * PW'(signed'({1'b0, regs.scale_factor}));

    case (state.mode)
      MODE_P2: which = 2'd1;
      MODE_P3: which = 2'd2;
      MODE_P4: which = 2'd3;
      default: which = 2'd0;
    endcase
    seeking_preset = (state.mode inside {MODE_P1, MODE_P2, MODE_P3, MODE_P4});

    target   = EW'(signed'({1'b0, regs.preset_pos[which]}));
    err_full = target - EW'(pos);
    mag      = err_full[EW-1] ? EW'(-err_full) : EW'(err_full);

    any_preset = |btn.preset;
    other      = btn.button_up || btn.button_down || |(btn.preset & ~(4'b0001 << which));

    // hysteresis: leave_threshold to start seeking, settle_threshold to stop
    seek_new = state.seeking;
    err_cmp  = '0;
    if (!state.seeking) begin
      if (mag > EW'(regs.leave_threshold)) begin
        seek_new = 1'b1;
        err_cmp  = err_full;
      end
    end else if (mag < EW'(regs.settle_threshold)) begin
      seek_new = 1'b0;
    end else begin
      err_cmp = err_full;
    end

    state_next = state;
    error      = '0;
    case (state.mode)
      MODE_IDLE: begin
        if (!any_preset) begin
          if (btn.button_up && !btn.button_down) begin
            state_next.drive = DRV_UP;
            state_next.mode  = MODE_UP;
          end else if (!btn.button_up && btn.button_down) begin
            state_next.drive = DRV_DOWN;
            state_next.mode  = MODE_DOWN;
          end
        end else if (!btn.button_up && !btn.button_down) begin
          // lowest numbered preset wins
          if (btn.preset[0])      state_next.mode = MODE_P1;
          else if (btn.preset[1]) state_next.mode = MODE_P2;
          else if (btn.preset[2]) state_next.mode = MODE_P3;
          else                    state_next.mode = MODE_P4;
        end
      end
      MODE_UP: begin
        if (!btn.button_up) begin
          state_next.drive = DRV_STOP;
          state_next.mode  = MODE_IDLE;
        end
      end
      MODE_DOWN: begin
        if (!btn.button_down) begin
          state_next.drive = DRV_STOP;
          state_next.mode  = MODE_IDLE;
        end
      end
      MODE_P1, MODE_P2, MODE_P3, MODE_P4: begin
        if (other) begin
          // abort keeps the comparator state
          state_next.drive = DRV_STOP;
          state_next.mode  = MODE_IDLE;
        end else begin
          state_next.seeking = seek_new;
          if (err_cmp > 0) begin
            state_next.drive = DRV_UP;
          end else if (err_cmp < 0) begin
            state_next.drive = DRV_DOWN;
          end else begin
            state_next.drive = DRV_STOP;
            state_next.mode  = MODE_IDLE;
          end
          if (err_cmp > EW'(ERR_MAX))      error = ERR_MAX;
          else if (err_cmp < EW'(ERR_MIN)) error = ERR_MIN;
          else                             error = err_cmp[ERR_BITS-1:0];
        end
      end
      default: state_next.mode = MODE_IDLE;
    endcase
    if (!seeking_preset) state_next.seeking = state.seeking;
  end

endmodule

// ===== hdl/arm_preset_position_controller_top.sv =====
// Shoulder arm preset controller. Each input word is one control tick: the manual
// up/down buttons, four preset buttons and a pot sample. Position is
// scale_factor * (sample_full_scale - sample); a preset drives the motor bang-bang
// toward its target through a hysteresis comparator, manual buttons drive while held,
// any other button aborts a preset. One word is accepted every cycle while ready is high;
// each word passes through the input register, then the result register.
// While a result waits to be taken the block holds at most one more word in its input
// register and then drops ready until the result goes. Configuration writes are
// accepted at any time and take effect the next cycle; write them only while idle.
module arm_preset_position_controller_top
  import apc_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  apc_cfg_if.sink                      cfg,
  apc_item_if.sink                     item,
  apc_result_if.source                 result
);

  cfg_t                         regs;
  state_t                       state;
  state_t                       state_next;
  logic                         in_valid;
  buttons_t                     in_btn;
  logic [SAMPLE_BITS-1:0]       in_sample;
  logic                         advance;
  logic signed [ERR_BITS-1:0]   error;

  apc_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  apc_step #(.SAMPLE_BITS(SAMPLE_BITS)) u_step (
    .regs       (regs),
    .state      (state),
    .btn        (in_btn),
    .sample     (in_sample),
    .state_next (state_next),
    .error      (error)
  );

  assign advance    = in_valid && (!result.valid || result.ready);
  assign item.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_btn.button_up   <= item.button_up;
      in_btn.button_down <= item.button_down;
      in_btn.preset      <= {item.preset_four, item.preset_three,
                             item.preset_two, item.preset_one};
      in_sample          <= item.shoulder_sample;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode    <= MODE_IDLE;
      state.seeking <= 1'b0;
      state.drive   <= DRV_STOP;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.motor_drive    <= state_next.drive;
      result.control_mode   <= state_next.mode;
      result.position_error <= error;
    end
  end

endmodule

// ===== hdl/apc_checker.sv =====
module apc_checker
  import apc_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [1:0]                 motor_drive,
  input logic [2:0]                 control_mode,
  input logic signed [ERR_BITS-1:0] position_error
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(motor_drive)
      && $stable(control_mode) && $stable(position_error))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> motor_drive != 2'd3 && control_mode != 3'd7)
    else $error("unused drive or mode code");

  // an error is only reported while a preset is being sought
  assert property (@(posedge clk) disable iff (rst)
    result_valid && position_error != 0 |->
      control_mode == MODE_P1 || control_mode == MODE_P2 ||
      control_mode == MODE_P3 || control_mode == MODE_P4)
    else $error("error outside preset mode");

  // drive direction follows error sign
  assert property (@(posedge clk) disable iff (rst)
    result_valid && position_error != 0 |->
      (position_error > 0 && motor_drive == DRV_UP) ||
      (position_error < 0 && motor_drive == DRV_DOWN))
    else $error("drive does not match error sign");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind arm_preset_position_controller_top apc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .motor_drive    (result.motor_drive),
  .control_mode   (result.control_mode),
  .position_error (result.position_error)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import apc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_TICKS = 250;

  typedef struct packed {
    logic                 up;
    logic                 down;
    logic [3:0]           press;
    logic [FULL_BITS-1:0] sample;
  } tick_t;

  typedef struct packed {
    drive_t                      drive;
    mode_t                       mode;
    logic signed [ERR_BITS-1:0]  err;
  } arm_word_t;

  logic clk;
  logic rst;

  apc_cfg_if                                 cfg_bus ();
  apc_item_if #(.SAMPLE_BITS(FULL_BITS))     item_bus ();
  apc_result_if                              result_bus ();

  arm_preset_position_controller_top #(.SAMPLE_BITS(FULL_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  // predictor copy of the arm controller
  mode_t                arm_mode;
  logic                 arm_seeking;
  drive_t               arm_drive;
  logic [11:0]          target_mrad [4];
  logic [3:0]           scale;
  logic [FULL_BITS-1:0] full;
  logic [7:0]           settle;
  logic [7:0]           leave;

  tick_t     pending_ticks [$];
  arm_word_t awaited_words [$];
  tick_t     staged_tick;
  arm_word_t oldest_word;

  logic item_fire;
  int   send_gap;
  int   stall_left;
  int   send_odds;
  int   stall_odds;
  int   queued_ticks;
  int   failures;
  int   cycles;

  function automatic arm_word_t advance_arm(logic up, logic down, logic [3:0] press,
                                            logic [FULL_BITS-1:0] sample);
    int        err;
    int        pos;
    int        mag;
    int        which;
    logic      other;
    arm_word_t w;
    err = 0;
    case (arm_mode)
      MODE_IDLE: begin
        if (press == 4'b0000) begin
          if (up && !down) begin
            arm_drive = DRV_UP;
            arm_mode = MODE_UP;
          end else if (!up && down) begin
            arm_drive = DRV_DOWN;
            arm_mode = MODE_DOWN;
          end
        end else if (!up && !down) begin
          // lowest numbered preset wins
          if (press[0]) arm_mode = MODE_P1;
          else if (press[1]) arm_mode = MODE_P2;
          else if (press[2]) arm_mode = MODE_P3;
          else arm_mode = MODE_P4;
        end
      end
      MODE_UP: begin
        if (!up) begin
          arm_drive = DRV_STOP;
          arm_mode = MODE_IDLE;
        end
      end
      MODE_DOWN: begin
        if (!down) begin
          arm_drive = DRV_STOP;
          arm_mode = MODE_IDLE;
        end
      end
      MODE_P1, MODE_P2, MODE_P3, MODE_P4: begin
        which = int'(arm_mode) - int'(MODE_P1);
        other = up || down || ((press & ~(4'b0001 << which)) != 4'b0000);
        if (other) begin
          // abort keeps the seeking flag as it is
          arm_drive = DRV_STOP;
          arm_mode = MODE_IDLE;
        end else begin
          pos = int'(scale) * (int'(full) - int'(sample));
          err = int'(target_mrad[which]) - pos;
          mag = (err < 0) ? -err : err;
          if (!arm_seeking) begin
            if (mag > int'(leave)) arm_seeking = 1'b1;
            else err = 0;
          end else if (mag < int'(settle)) begin
            arm_seeking = 1'b0;
            err = 0;
          end
          if (err > 0) begin
            arm_drive = DRV_UP;
          end else if (err < 0) begin
            arm_drive = DRV_DOWN;
          end else begin
            arm_drive = DRV_STOP;
            arm_mode = MODE_IDLE;
          end
        end
      end
      default: arm_mode = MODE_IDLE;
    endcase
    if (err > int'(ERR_MAX)) err = int'(ERR_MAX);
    if (err < int'(ERR_MIN)) err = int'(ERR_MIN);
    w.drive = arm_drive;
    w.mode = arm_mode;
    w.err = err[ERR_BITS-1:0];
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_fire) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        item_bus.valid <= 1'b0;
      end else if (send_odds != 0 && $urandom_range(1, 100) <= send_odds) begin
        send_gap <= $urandom_range(0, 18);
        item_bus.valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        staged_tick = pending_ticks.pop_front();
        item_bus.valid <= 1'b1;
        item_bus.button_up <= staged_tick.up;
        item_bus.button_down <= staged_tick.down;
        item_bus.preset_one <= staged_tick.press[0];
        item_bus.preset_two <= staged_tick.press[1];
        item_bus.preset_three <= staged_tick.press[2];
        item_bus.preset_four <= staged_tick.press[3];
        item_bus.shoulder_sample <= staged_tick.sample;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_bus.ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
      stall_left <= $urandom_range(0, 18);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // monitor: predict on every accepted tick, check every accepted result
  always @(posedge clk) begin
    if (rst) begin
      item_fire <= 1'b0;
    end else begin
      item_fire <= item_bus.valid && item_bus.ready;
      if (item_bus.valid && item_bus.ready)
        awaited_words.push_back(advance_arm(item_bus.button_up, item_bus.button_down,
          {item_bus.preset_four, item_bus.preset_three, item_bus.preset_two,
           item_bus.preset_one}, item_bus.shoulder_sample));
      if (result_bus.valid && result_bus.ready) begin
        if (awaited_words.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result word: drive %0d mode %0d error %0d",
                     result_bus.motor_drive, result_bus.control_mode,
                     result_bus.position_error);
        end else begin
          oldest_word = awaited_words.pop_front();
          if (result_bus.motor_drive !== oldest_word.drive ||
              result_bus.control_mode !== oldest_word.mode ||
              result_bus.position_error !== oldest_word.err) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: drive exp %0d got %0d, mode exp %0d got %0d, error exp %0d got %0d",
                       oldest_word.drive, result_bus.motor_drive, oldest_word.mode,
                       result_bus.control_mode, oldest_word.err, result_bus.position_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_tick(logic up, logic down, logic [3:0] press, int sample);
    tick_t t;
    t.up = up;
    t.down = down;
    t.press = press;
    t.sample = sample[FULL_BITS-1:0];
    pending_ticks.push_back(t);
    queued_ticks++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = index;
    cfg_bus.data = data;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    case (index)
      REG_PRESET_ONE:   target_mrad[0] = data;
      REG_PRESET_TWO:   target_mrad[1] = data;
      REG_PRESET_THREE: target_mrad[2] = data;
      REG_PRESET_FOUR:  target_mrad[3] = data;
      REG_SCALE:        scale = data[3:0];
      REG_FULL_SCALE:   full = data[FULL_BITS-1:0];
      REG_SETTLE:       settle = data[7:0];
      REG_LEAVE:        leave = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic load_settings(int p1, int p2, int p3, int p4, int sc, int fs, int st, int lv);
    write_reg(REG_PRESET_ONE, p1[11:0]);
    write_reg(REG_PRESET_TWO, p2[11:0]);
    write_reg(REG_PRESET_THREE, p3[11:0]);
    write_reg(REG_PRESET_FOUR, p4[11:0]);
    write_reg(REG_SCALE, sc[11:0]);
    write_reg(REG_FULL_SCALE, fs[11:0]);
    write_reg(REG_SETTLE, st[11:0]);
    write_reg(REG_LEAVE, lv[11:0]);
  endtask

  // wait until every tick went in and every result came back
  task automatic drain();
    while (pending_ticks.size() != 0 || item_bus.valid || awaited_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sample that puts the arm on a preset target
  function automatic int aim_sample(int which);
    int s;
    if (scale == 4'd0) return $urandom_range(0, 1023);
    s = int'(full) - int'(target_mrad[which]) / int'(scale);
    if (s < 0) s = 0;
    if (s > 1023) s = 1023;
    return s;
  endfunction

  // preset press, then the arm walks toward the target with some jitter and may be aborted by another button
  task automatic preset_episode();
    int         which;
    int         goal;
    int         s;
    int         len;
    int         gap_to_goal;
    int         stride;
    int         abort_kind;
    logic [3:0] press;
    logic [3:0] hold;
    logic       done;
    which = $urandom_range(0, 3);
    press = 4'b0001 << which;
    hold = $urandom_range(0, 1) ? press : 4'b0000;
    goal = aim_sample(which);
    s = $urandom_range(0, 1023);
    done = 1'b0;
    queue_tick(1'b0, 1'b0, 4'b0000, s);
    queue_tick(1'b0, 1'b0, press, s);
    len = $urandom_range(2, 40);
    for (int k = 0; k < len && !done; k++) begin
      gap_to_goal = goal - s;
      stride = ((gap_to_goal < 0) ? -gap_to_goal : gap_to_goal) / 4 + $urandom_range(0, 2);
      if (gap_to_goal > 0) s = s + stride;
      else if (gap_to_goal < 0) s = s - stride;
      else s = s + $urandom_range(0, 4) - 2;
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      if ($urandom_range(0, 11) == 0) begin
        abort_kind = $urandom_range(0, 2);
        if (abort_kind == 0) queue_tick(1'b1, 1'b0, hold, s);
        else if (abort_kind == 1) queue_tick(1'b0, 1'b1, hold, s);
        else queue_tick(1'b0, 1'b0,
                        press | (4'b0001 << ((which + 1 + $urandom_range(0, 2)) % 4)), s);
        done = 1'b1;
      end else begin
        queue_tick(1'b0, 1'b0, hold, s);
      end
    end
  endtask

  task automatic manual_episode();
    logic up;
    logic down;
    int   len;
    up = $urandom_range(0, 1);
    down = !up;
    if ($urandom_range(0, 7) == 0) begin
      up = 1'b1;
      down = 1'b1;
    end
    len = $urandom_range(1, 12);
    queue_tick(up, down, 4'b0000, $urandom_range(0, 1023));
    repeat (len)
      queue_tick(up, down, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'b0000,
                 $urandom_range(0, 1023));
    queue_tick(1'b0, 1'b0, 4'b0000, $urandom_range(0, 1023));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4))
      queue_tick($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                 4'($urandom_range(0, 15)) & 4'($urandom_range(0, 15)),
                 $urandom_range(0, 1023));
  endtask

  initial begin : stimulus
    int goal_ticks;
    int pick;
    int lo;
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    item_bus.valid = 1'b0;
    item_bus.button_up = 1'b0;
    item_bus.button_down = 1'b0;
    item_bus.preset_one = 1'b0;
    item_bus.preset_two = 1'b0;
    item_bus.preset_three = 1'b0;
    item_bus.preset_four = 1'b0;
    item_bus.shoulder_sample = '0;
    result_bus.ready = 1'b0;
    arm_mode = MODE_IDLE;
    arm_seeking = 1'b0;
    arm_drive = DRV_STOP;
    target_mrad[0] = 12'd4;
    target_mrad[1] = 12'd180;
    target_mrad[2] = 12'd676;
    target_mrad[3] = 12'd1140;
    scale = 4'd4;
    full = 10'd1023;
    settle = 8'd20;
    leave = 8'd45;
    item_fire = 1'b0;
    send_gap = 0;
    stall_left = 0;
    send_odds = 10;
    stall_odds = 10;
    queued_ticks = 0;
    failures = 0;
    cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // manual buttons on the reset settings
    queue_tick(1'b0, 1'b0, 4'b0000, 0);
    queue_tick(1'b1, 1'b1, 4'b0000, 1023);
    queue_tick(1'b1, 1'b0, 4'b0000, 512);
    queue_tick(1'b1, 1'b0, 4'b1111, 100);
    queue_tick(1'b0, 1'b0, 4'b0000, 200);
    queue_tick(1'b0, 1'b1, 4'b0000, 300);
    queue_tick(1'b0, 1'b0, 4'b0000, 300);
    queue_tick(1'b1, 1'b0, 4'b0001, 0);
    // two presets at once, then seek until the target is reached
    queue_tick(1'b0, 1'b0, 4'b1010, 1023);
    queue_tick(1'b0, 1'b0, 4'b0010, 1023);
    queue_tick(1'b0, 1'b0, 4'b0000, 978);
    // seek, overshoot, abort with another preset
    queue_tick(1'b0, 1'b0, 4'b1000, 1023);
    queue_tick(1'b0, 1'b0, 4'b0000, 1023);
    queue_tick(1'b0, 1'b0, 4'b0000, 0);
    queue_tick(1'b0, 1'b0, 4'b0001, 0);
    // still seeking inside the hysteresis band, then settle
    queue_tick(1'b0, 1'b0, 4'b1000, 0);
    queue_tick(1'b0, 1'b0, 4'b0000, 730);
    queue_tick(1'b0, 1'b0, 4'b0000, 738);
    // already in position: stops at once
    queue_tick(1'b0, 1'b0, 4'b1000, 0);
    queue_tick(1'b0, 1'b0, 4'b0000, 731);
    drain();

    // error beyond the positive output range
    write_reg(REG_PRESET_ONE, 12'd4095);
    write_reg(REG_SCALE, 12'd15);
    write_reg(REG_FULL_SCALE, 12'd0);
    write_reg(REG_SETTLE, 12'd255);
    write_reg(REG_LEAVE, 12'd0);
    write_reg(REG_LEAVE + 8'($urandom_range(1, 248)), 12'($urandom_range(0, 4095)));
    queue_tick(1'b0, 1'b0, 4'b0001, 1023);
    queue_tick(1'b0, 1'b0, 4'b0001, 1023);
    queue_tick(1'b0, 1'b1, 4'b0000, 0);
    drain();

    // most negative error
    write_reg(REG_PRESET_TWO, 12'd0);
    write_reg(REG_FULL_SCALE, 12'd1023);
    queue_tick(1'b0, 1'b0, 4'b0010, 0);
    queue_tick(1'b0, 1'b0, 4'b0010, 0);
    queue_tick(1'b0, 1'b0, 4'b0000, 1023);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          load_settings(4, 180, 676, 1140, 4, 1023, 20, 45);
          send_odds = 10;
          stall_odds = 10;
        end
        1: begin
          load_settings(4095, 4095, 4095, 4095, 15, 1023, 255, 255);
          send_odds = 0;
          stall_odds = 20;
        end
        2: begin
          load_settings(0, 0, 0, 0, 1, 0, 0, 0);
          send_odds = 20;
          stall_odds = 0;
        end
        3: begin
          load_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
          send_odds = 30;
          stall_odds = 30;
        end
        4: begin
          lo = $urandom_range(0, 60);
          load_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(1, 8), $urandom_range(0, 1023),
                        lo, lo + $urandom_range(0, 60));
          send_odds = 5;
          stall_odds = 5;
        end
        default: begin
          // closing stretch runs back to back
          load_settings(4, 180, 676, 1140, 4, 1023, 20, 45);
          send_odds = 0;
          stall_odds = 0;
        end
      endcase
      goal_ticks = queued_ticks + PHASE_TICKS;
      while (queued_ticks < goal_ticks) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) preset_episode();
        else if (pick < 7) manual_episode();
        else noise_burst();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/apc_pkg.sv
hdl/apc_item_if.sv
hdl/apc_result_if.sv
hdl/apc_cfg_if.sv
hdl/apc_cfg_regs.sv
hdl/apc_step.sv
hdl/arm_preset_position_controller_top.sv
hdl/apc_checker.sv
tb/testbench.sv
